// ===== sv/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

   // fixed field widths
   localparam int CHAR_W      = 8;
   localparam int ADDR_W      = 13;
   localparam int CELL_W      = 16;
   localparam int ROWS_W      = 6;
   localparam int COLS_W      = 7;
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;

   localparam int QUEUE_DEPTH = 2;

   // character codes and cell attribute
   localparam logic [CHAR_W-1:0] CHAR_CR   = 8'd13;
   localparam logic [CHAR_W-1:0] CHAR_LF   = 8'd10;
   localparam logic [CHAR_W-1:0] ATTR_GREY = 8'h07;

   // opcode carried in req_tuser
   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   // geometry after reset
   localparam logic [ROWS_W-1:0] RESET_ROWS = 6'd25;
   localparam logic [COLS_W-1:0] RESET_COLS = 7'd80;

   typedef enum logic {
      CSR_ROWS,
      CSR_COLS
   } csr_index_type;

   typedef enum logic [1:0] {
      CMD_PUT,
      CMD_CR,
      CMD_LF,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [CHAR_W-1:0] char_code;
      logic [ADDR_W-1:0] cell_address;
   } cmd_type;

endpackage

`default_nettype wire

// ===== sv/tcw_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4800
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire                      rd_en,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== sv/tcw_queue.sv =====
// Short command queue between the front and back parts.
`default_nettype none

module tcw_queue #(
   parameter int DEPTH = 2
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push_valid,
   output logic              push_ready,
   input  tcw_pkg::cmd_type  push_cmd,
   output logic              pop_valid,
   input  wire               pop_ready,
   output tcw_pkg::cmd_type  pop_cmd
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   tcw_pkg::cmd_type entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != NW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (!do_push && do_pop) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== sv/tcw_front.sv =====
// Front part: takes requests, classifies them and hands commands to the queue.
`default_nettype none

module tcw_front (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                hold,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire                                req_tuser,   // opcode
   input  wire  [tcw_pkg::REQ_TDATA_W-1:0]    req_tdata,   // char_code, cell_address, pad
   output logic                               push_valid,
   input  wire                                push_ready,
   output tcw_pkg::cmd_type                   push_cmd
);

   logic             slot_valid_ff, slot_valid_in;
   tcw_pkg::cmd_type slot_cmd_ff, slot_cmd_in;
   tcw_pkg::cmd_type cls_cmd;
   logic             accept;

   assign req_tready = !hold && (!slot_valid_ff || push_ready);
   assign accept     = req_tvalid && req_tready;
   assign push_valid = slot_valid_ff;
   assign push_cmd   = slot_cmd_ff;

   always_comb begin
      cls_cmd.char_code    = req_tdata[tcw_pkg::CHAR_W-1:0];
      cls_cmd.cell_address = req_tdata[tcw_pkg::CHAR_W +: tcw_pkg::ADDR_W];
      if (req_tuser == tcw_pkg::OP_READ) begin
         cls_cmd.kind = tcw_pkg::CMD_READ;
      end else begin
         case (req_tdata[tcw_pkg::CHAR_W-1:0])
            tcw_pkg::CHAR_CR: cls_cmd.kind = tcw_pkg::CMD_CR;
            tcw_pkg::CHAR_LF: cls_cmd.kind = tcw_pkg::CMD_LF;
            default:          cls_cmd.kind = tcw_pkg::CMD_PUT;
         endcase
      end
   end

   always_comb begin
      slot_valid_in = slot_valid_ff;
      slot_cmd_in   = slot_cmd_ff;
      if (accept) begin
         slot_valid_in = 1'b1;
         slot_cmd_in   = cls_cmd;
      end else if (push_ready) begin
         slot_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
      slot_cmd_ff <= slot_cmd_in;
   end

endmodule

`default_nettype wire

// ===== sv/tcw_back.sv =====
// Back part: cursor, screen store, scroll sequencer and response register.
`default_nettype none

module tcw_back #(
   parameter int MAX_ROWS    = 60,
   parameter int MAX_COLUMNS = 80
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire  [tcw_pkg::ROWS_W-1:0]         cfg_rows,
   input  wire  [tcw_pkg::COLS_W-1:0]         cfg_cols,
   output logic                               init_busy,
   input  wire                                pop_valid,
   output logic                               pop_ready,
   input  tcw_pkg::cmd_type                   pop_cmd,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [tcw_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // crtc_cursor, read_data, pad
   output logic                               rsp_tuser    // scrolled
);

   localparam int CELLS = MAX_ROWS * MAX_COLUMNS;
   localparam int AW    = $clog2(CELLS);
   localparam int RW    = $clog2(MAX_ROWS + 1);
   localparam int CW    = $clog2(MAX_COLUMNS + 1);
   localparam int RIW   = $clog2(MAX_ROWS);
   localparam int CIW   = $clog2(MAX_COLUMNS);
   localparam int RESET_ROW =
      ((int'(tcw_pkg::RESET_ROWS) > MAX_ROWS) ? MAX_ROWS : int'(tcw_pkg::RESET_ROWS)) - 1;
   localparam int PAD_W = tcw_pkg::RSP_TDATA_W - tcw_pkg::ADDR_W - tcw_pkg::CELL_W;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_PUT,
      ST_PREP,
      ST_COPY,
      ST_ZERO,
      ST_DONE
   } state_type;

   state_type                    state_ff, state_in;
   logic [RIW-1:0]               row_ff, row_in;
   logic [CIW-1:0]               col_ff, col_in;
   logic [AW-1:0]                sweep_ff, sweep_in;
   logic [AW-1:0]                keep_ff, keep_in;
   logic                         pend_ff, pend_in;
   logic [AW-1:0]                pend_addr_ff, pend_addr_in;
   logic [tcw_pkg::CHAR_W-1:0]   char_ff, char_in;
   logic [tcw_pkg::CELL_W-1:0]   data_ff, data_in;
   logic                         scrolled_ff, scrolled_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::ADDR_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [tcw_pkg::CELL_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                         rsp_scrolled_ff, rsp_scrolled_in;

   logic [RW-1:0]                rows_use, rows_m1;
   logic [CW-1:0]                cols_use, cols_m1;
   logic [RIW-1:0]               row_sat, down_src, down_row;
   logic [CIW-1:0]               col_sat;
   logic [CW-1:0]                col_inc;
   logic                         down_hit;
   logic [AW-1:0]                lin;
   logic                         take;
   logic                         addr_ok;

   logic                         ram_we, ram_re;
   logic [AW-1:0]                ram_wa, ram_ra;
   logic [tcw_pkg::CELL_W-1:0]   ram_wd, ram_rd;

   tcw_ram #(
      .WIDTH (tcw_pkg::CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   // geometry in use, saturated to 1..MAX
   always_comb begin
      if (cfg_rows == '0) begin
         rows_use = RW'(1);
      end else if (int'(cfg_rows) > MAX_ROWS) begin
         rows_use = RW'(MAX_ROWS);
      end else begin
         rows_use = RW'(cfg_rows);
      end
      if (cfg_cols == '0) begin
         cols_use = CW'(1);
      end else if (int'(cfg_cols) > MAX_COLUMNS) begin
         cols_use = CW'(MAX_COLUMNS);
      end else begin
         cols_use = CW'(cfg_cols);
      end
   end

   assign rows_m1 = rows_use - RW'(1);
   assign cols_m1 = cols_use - CW'(1);

   // cursor clipped to the geometry in use
   assign row_sat = (RW'(row_ff) >= rows_use) ? RIW'(rows_m1) : row_ff;
   assign col_sat = (CW'(col_ff) >= cols_use) ? CIW'(cols_m1) : col_ff;

   // one row down, from the clipped row in IDLE or the stored row otherwise
   assign down_src = (state_ff == ST_IDLE) ? row_sat : row_ff;
   assign down_hit = (RW'(down_src) + RW'(1)) >= rows_use;
   assign down_row = down_hit ? RIW'(rows_m1) : down_src + RIW'(1);

   assign col_inc  = CW'(col_ff) + CW'(1);
   assign lin      = AW'(row_ff) * AW'(cols_use) + AW'(col_ff);
   assign addr_ok  = {1'b0, pop_cmd.cell_address} < (tcw_pkg::ADDR_W + 1)'(CELLS);

   assign init_busy  = (state_ff == ST_INIT);
   assign pop_ready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign take       = pop_valid && pop_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_scrolled_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_data_ff, rsp_pos_ff};

   always_comb begin
      state_in        = state_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      sweep_in        = sweep_ff;
      keep_in         = keep_ff;
      pend_in         = pend_ff;
      pend_addr_in    = pend_addr_ff;
      char_in         = char_ff;
      data_in         = data_ff;
      scrolled_in     = scrolled_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_tready;
      rsp_pos_in      = rsp_pos_ff;
      rsp_data_in     = rsp_data_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      ram_we          = 1'b0;
      ram_wa          = sweep_ff;
      ram_wd          = '0;
      ram_re          = 1'b0;
      ram_ra          = pop_cmd.cell_address[AW-1:0];

      case (state_ff)
         ST_INIT: begin
            ram_we   = 1'b1;
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == AW'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (take) begin
               row_in      = row_sat;
               col_in      = col_sat;
               data_in     = '0;
               scrolled_in = 1'b0;
               char_in     = pop_cmd.char_code;
               state_in    = ST_DONE;
               case (pop_cmd.kind)
                  tcw_pkg::CMD_READ: begin
                     if (addr_ok) begin
                        ram_re   = 1'b1;
                        state_in = ST_READ;
                     end
                  end
                  tcw_pkg::CMD_CR: begin
                     col_in = '0;
                  end
                  tcw_pkg::CMD_LF: begin
                     row_in = down_row;
                     if (down_hit) begin
                        scrolled_in = 1'b1;
                        state_in    = ST_PREP;
                     end
                  end
                  default: begin
                     state_in = ST_PUT;
                  end
               endcase
            end
         end

         ST_READ: begin
            data_in  = ram_rd;
            state_in = ST_DONE;
         end

         ST_PUT: begin
            ram_we   = 1'b1;
            ram_wa   = lin;
            ram_wd   = {tcw_pkg::ATTR_GREY, char_ff};
            state_in = ST_DONE;
            if (col_inc >= cols_use) begin
               col_in = '0;
               row_in = down_row;
               if (down_hit) begin
                  scrolled_in = 1'b1;
                  state_in    = ST_PREP;
               end
            end else begin
               col_in = CIW'(col_inc);
            end
         end

         ST_PREP: begin
            keep_in  = AW'(rows_m1) * AW'(cols_use);
            sweep_in = '0;
            pend_in  = 1'b0;
            state_in = ST_COPY;
         end

         // read one row ahead, write the word back in the next cycle
         ST_COPY: begin
            ram_we = pend_ff;
            ram_wa = pend_addr_ff;
            ram_wd = ram_rd;
            if (sweep_ff != keep_ff) begin
               ram_re       = 1'b1;
               ram_ra       = sweep_ff + AW'(cols_use);
               pend_in      = 1'b1;
               pend_addr_in = sweep_ff;
               sweep_in     = sweep_ff + AW'(1);
            end else begin
               pend_in  = 1'b0;
               state_in = ST_ZERO;
            end
         end

         // blank the bottom row
         ST_ZERO: begin
            ram_we   = 1'b1;
            sweep_in = sweep_ff + AW'(1);
            if (sweep_ff == keep_ff + AW'(cols_m1)) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            rsp_valid_in    = 1'b1;
            rsp_pos_in      = tcw_pkg::ADDR_W'(lin);
            rsp_data_in     = data_ff;
            rsp_scrolled_in = scrolled_ff;
            state_in        = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         row_ff       <= RIW'(RESET_ROW);
         col_ff       <= '0;
         sweep_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         sweep_ff     <= sweep_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      keep_ff         <= keep_in;
      pend_addr_ff    <= pend_addr_in;
      char_ff         <= char_in;
      data_ff         <= data_in;
      scrolled_ff     <= scrolled_in;
      rsp_pos_ff      <= rsp_pos_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

endmodule

`default_nettype wire

// ===== sv/text_console_writer_core.sv =====
// Top level of the text console writer: geometry registers, front, queue, back.
//
// Text-mode console over a screen store of 16-bit cells (attribute high byte,
// character low byte). Each request on req_ is either a put (req_tuser = 0) or
// a cell read (req_tuser = 1). A put stores 0x07 plus the character at the
// cursor and moves right with wrap; carriage return homes the column and line
// feed moves down a row. Moving below the last row scrolls the screen up and
// blanks the bottom row. Every request gives one response on rsp_ carrying the
// linear cursor position (the CRTC 0x0E/0x0F value), the cell read (zero for
// puts) and a scroll flag in rsp_tuser.
// Geometry is set on csr_ (index 0 rows, index 1 columns) by the user only
// while idle; the block itself does not enforce this. The back part goes
// from IDLE via PUT (puts) or READ (in-store reads) to DONE, which loads the
// response register, and takes the next command only back in IDLE. A scroll
// adds PREP, COPY and ZERO, one cell moved or cleared per cycle. After reset
// the MAX_ROWS*MAX_COLUMNS cells (4800 by default) are swept to zero with
// req_tready low; csr writes are taken meanwhile. A stalled rsp_tready holds
// the response; the front and the two-entry queue keep taking requests until
// they fill.
`default_nettype none

module text_console_writer_core #(
   parameter int MAX_ROWS    = 60,
   parameter int MAX_COLUMNS = 80
) (
   input  wire                                clock,
   input  wire                                reset,
   // request channel
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire                                req_tuser,   // [0] opcode
   input  wire  [tcw_pkg::REQ_TDATA_W-1:0]    req_tdata,   // [7:0] char_code, [20:8] cell_address
   // response channel
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic                               rsp_tuser,   // [0] scrolled
   output logic [tcw_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [12:0] crtc_cursor, [28:13] read_data
   // geometry register writes
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  tcw_pkg::csr_index_type             csr_index,
   input  wire  [tcw_pkg::COLS_W-1:0]         csr_data
);

   logic [tcw_pkg::ROWS_W-1:0] rows_ff, rows_in;
   logic [tcw_pkg::COLS_W-1:0] cols_ff, cols_in;

   logic             init_busy;
   logic             push_valid, push_ready;
   tcw_pkg::cmd_type push_cmd;
   logic             pop_valid, pop_ready;
   tcw_pkg::cmd_type pop_cmd;

   // registers always take a write at once
   assign csr_ready = 1'b1;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            tcw_pkg::CSR_ROWS: rows_in = csr_data[tcw_pkg::ROWS_W-1:0];
            tcw_pkg::CSR_COLS: cols_in = csr_data;
            default:           rows_in = rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= tcw_pkg::RESET_ROWS;
         cols_ff <= tcw_pkg::RESET_COLS;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   // front: classify requests (CR, LF, put, read)
   tcw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .hold       (init_busy),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   tcw_queue #(
      .DEPTH (tcw_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   // back: cursor update, store access, scroll, response register
   tcw_back #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg_rows   (rows_ff),
      .cfg_cols   (cols_ff),
      .init_busy  (init_busy),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
